/* src/pse_pkg.sv */
// Shared types, constants and helpers for the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int ITER_W      = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_DIVZERO   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
        logic                     final_res;
    } t_out_item;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

    function automatic logic is_operator(input logic [SYM_W-1:0] sym);
        return (sym == CH_PLUS) || (sym == CH_MINUS) ||
               (sym == CH_STAR) || (sym == CH_SLASH);
    endfunction

    function automatic t_alu_op op_of(input logic [SYM_W-1:0] sym);
        t_alu_op op;
        op = OP_DIV;
        if (sym == CH_PLUS) begin
            op = OP_ADD;
        end else if (sym == CH_MINUS) begin
            op = OP_SUB;
        end else if (sym == CH_STAR) begin
            op = OP_MUL;
        end
        return op;
    endfunction

endpackage

/* src/pse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/pse_alu.sv */
// Iterative arithmetic unit: one shared 33-bit adder serves add, subtract,
// shift-add multiply and restoring divide.
module pse_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_alu_req i_req,
    output pse_pkg::t_alu_rsp o_rsp
);

    typedef enum logic [7:0] {
        A_IDLE   = 8'b0000_0001,
        A_ADDSUB = 8'b0000_0010,
        A_ABSA   = 8'b0000_0100,
        A_ABSB   = 8'b0000_1000,
        A_MUL    = 8'b0001_0000,
        A_DIV    = 8'b0010_0000,
        A_NEGQ   = 8'b0100_0000,
        A_DONE   = 8'b1000_0000
    } t_alu_state;

    t_alu_state r_state, n_state;
    pse_pkg::t_alu_op r_op, n_op;
    logic [pse_pkg::DATA_W-1:0] r_a, n_a;
    logic [pse_pkg::DATA_W-1:0] r_b, n_b;
    logic [pse_pkg::DATA_W-1:0] r_acc, n_acc;
    logic [pse_pkg::DATA_W-1:0] r_res, n_res;
    logic [pse_pkg::ITER_W-1:0] r_cnt, n_cnt;
    logic r_neg, n_neg;

    logic [pse_pkg::DATA_W:0] w_x, w_y, w_sum;
    logic w_sub;
    logic w_last_iter;

    assign w_last_iter = (r_cnt == pse_pkg::ITER_W'(pse_pkg::DATA_W - 1));

    // Operand selection for the shared adder.
    always_comb begin
        w_x   = {1'b0, r_a};
        w_y   = {1'b0, r_b};
        w_sub = 1'b0;
        unique case (r_state)
            A_ADDSUB: begin
                w_sub = (r_op == pse_pkg::OP_SUB);
            end
            A_ABSA: begin
                w_x   = '0;
                w_y   = {1'b0, r_a};
                w_sub = 1'b1;
            end
            A_ABSB: begin
                w_x   = '0;
                w_y   = {1'b0, r_b};
                w_sub = 1'b1;
            end
            A_MUL: begin
                w_x = {1'b0, r_acc};
                w_y = {1'b0, r_a};
            end
            A_DIV: begin
                // Partial remainder shifted left, next dividend bit brought in.
                w_x   = {r_acc, r_a[pse_pkg::DATA_W-1]};
                w_y   = {1'b0, r_b};
                w_sub = 1'b1;
            end
            A_NEGQ: begin
                w_x   = '0;
                w_y   = {1'b0, r_a};
                w_sub = 1'b1;
            end
            default: begin
            end
        endcase
        w_sum = w_x + (w_y ^ {(pse_pkg::DATA_W + 1){w_sub}})
              + {{pse_pkg::DATA_W{1'b0}}, w_sub};
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_res   = r_res;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_a   = i_req.lhs;
                    n_b   = i_req.rhs;
                    n_acc = '0;
                    n_cnt = '0;
                    n_neg = i_req.lhs[pse_pkg::DATA_W-1] ^ i_req.rhs[pse_pkg::DATA_W-1];
                    unique case (i_req.op)
                        pse_pkg::OP_ADD, pse_pkg::OP_SUB: n_state = A_ADDSUB;
                        pse_pkg::OP_MUL:                  n_state = A_MUL;
                        default:                          n_state = A_ABSA;
                    endcase
                end
            end
            A_ADDSUB: begin
                n_res   = w_sum[pse_pkg::DATA_W-1:0];
                n_state = A_DONE;
            end
            A_ABSA: begin
                if (r_a[pse_pkg::DATA_W-1]) begin
                    n_a = w_sum[pse_pkg::DATA_W-1:0];
                end
                n_state = A_ABSB;
            end
            A_ABSB: begin
                if (r_b[pse_pkg::DATA_W-1]) begin
                    n_b = w_sum[pse_pkg::DATA_W-1:0];
                end
                n_state = A_DIV;
            end
            A_MUL: begin
                if (r_b[0]) begin
                    n_acc = w_sum[pse_pkg::DATA_W-1:0];
                end
                n_a   = {r_a[pse_pkg::DATA_W-2:0], 1'b0};
                n_b   = {1'b0, r_b[pse_pkg::DATA_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (w_last_iter) begin
                    n_res   = r_b[0] ? w_sum[pse_pkg::DATA_W-1:0] : r_acc;
                    n_state = A_DONE;
                end
            end
            A_DIV: begin
                // A clear sign bit means the divisor fit: keep the difference.
                if (!w_sum[pse_pkg::DATA_W]) begin
                    n_acc = w_sum[pse_pkg::DATA_W-1:0];
                end else begin
                    n_acc = w_x[pse_pkg::DATA_W-1:0];
                end
                n_a   = {r_a[pse_pkg::DATA_W-2:0], ~w_sum[pse_pkg::DATA_W]};
                n_cnt = r_cnt + 1'b1;
                if (w_last_iter) begin
                    n_state = A_NEGQ;
                end
            end
            A_NEGQ: begin
                n_res   = r_neg ? w_sum[pse_pkg::DATA_W-1:0] : r_a;
                n_state = A_DONE;
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_res <= n_res;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_rsp.done   = (r_state == A_DONE);
    assign o_rsp.result = r_res;

endmodule

/* src/postfix_stack_evaluator.sv */
// Top level of the postfix stack evaluator: stack control, RAM and arithmetic unit.
//
// Usage: each input transfer carries one expression character and a last flag.
// Characters '+', '-', '*' and '/' pop the top two stack entries and push
// (second-from-top op top); any other byte is pushed as its value minus 48.
// Every input transfer yields exactly one output transfer with the new top of
// stack, the depth, a status code and a copy of the last flag. After an item
// marked last has reported, the stack is emptied.
// The top of stack lives in a register; the entries below it live in a RAM with
// a registered read port, so an operator fetches its second operand in S_READ.
// Path per item: push, overflow and underflow go straight to S_EMIT; divide by
// zero is caught in S_READ; add and subtract go through the shared arithmetic unit;
// multiply runs the 32-step shift-add loop of the shared arithmetic unit; divide
// runs the 32-step restoring divide loop plus sign fixups in the same unit.
// One item is in flight at a time: o_in_ready is high only while the sequencer
// is idle, so a new character is taken only after the last result is loaded.
// When the receiver stalls, the finished result waits in the output register and
// the sequencer holds before loading the following result until it drains.
// Synchronous reset empties the stack and drops any pending result; the RAM
// needs no clearing since only entries below the depth are ever read.
module postfix_stack_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pse_pkg::t_out_item o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [pse_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pse_pkg::DATA_W-1:0] r_top, n_top;
    logic [pse_pkg::SYM_W-1:0]  r_sym, n_sym;
    logic r_last, n_last;
    pse_pkg::t_status r_status, n_status;
    logic r_out_valid, n_out_valid;
    pse_pkg::t_out_item r_out_data, n_out_data;

    logic [pse_pkg::CNT_W-1:0]  w_count_m1, w_count_m2;
    logic                       ram_we, ram_re;
    logic [pse_pkg::DATA_W-1:0] ram_rdata;
    pse_pkg::t_alu_req          alu_req;
    pse_pkg::t_alu_rsp          alu_rsp;

    // Entry just below the top sits at depth-2 in the RAM: the RAM holds
    // everything except the top register.
    assign w_count_m1 = r_count - 1'b1;
    assign w_count_m2 = r_count - 2'd2;

    pse_ram #(
        .WIDTH(pse_pkg::DATA_W),
        .DEPTH(pse_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(w_count_m1[pse_pkg::ADDR_W-1:0]),
        .i_wr_data(r_top),
        .i_rd_en  (ram_re),
        .i_rd_addr(w_count_m2[pse_pkg::ADDR_W-1:0]),
        .o_rd_data(ram_rdata)
    );

    pse_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_sym       = r_sym;
        n_last      = r_last;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        alu_req     = '{start: 1'b0, op: pse_pkg::op_of(r_sym), lhs: ram_rdata, rhs: r_top};

        // The pending result leaves as soon as the receiver takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym    = i_in_data.symbol;
                    n_last   = i_in_data.last;
                    n_status = pse_pkg::STAT_OK;
                    if (pse_pkg::is_operator(i_in_data.symbol)) begin
                        if (r_count < pse_pkg::CNT_W'(2)) begin
                            n_status = pse_pkg::STAT_UNDERFLOW;
                            n_state  = S_EMIT;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                    end else begin
                        if (r_count >= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                            n_status = pse_pkg::STAT_OVERFLOW;
                        end else begin
                            // The old top moves down into the RAM.
                            ram_we  = (r_count != '0);
                            n_top   = pse_pkg::DATA_W'(i_in_data.symbol)
                                    - pse_pkg::DATA_W'(pse_pkg::CH_ZERO);
                            n_count = r_count + 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ: begin
                if ((r_sym == pse_pkg::CH_SLASH) && (r_top == '0)) begin
                    n_top    = '0;
                    n_count  = w_count_m1;
                    n_status = pse_pkg::STAT_DIVZERO;
                    n_state  = S_EMIT;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    n_top   = alu_rsp.result;
                    n_count = w_count_m1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_data.top_value  = (r_count != '0) ? r_top : '0;
                    n_out_data.depth      = pse_pkg::DEPTH_W'(r_count);
                    n_out_data.status     = r_status;
                    n_out_data.final_res  = r_last;
                    if (r_last) begin
                        n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top      <= n_top;
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/pse_checker.sv */
// Port-level assertions for the postfix stack evaluator, bound to the top level.
module pse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pse_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted a second item while one was in flight");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.depth == '0) |-> (o_out_data.top_value == '0))
        else $error("empty stack reported a nonzero top value");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == pse_pkg::STAT_OVERFLOW)
        |-> (o_out_data.depth == pse_pkg::DEPTH_W'(pse_pkg::STACK_DEPTH)))
        else $error("overflow reported on a stack that was not full");

    a_underflow_shallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == pse_pkg::STAT_UNDERFLOW)
        |-> (o_out_data.depth <= pse_pkg::DEPTH_W'(1)))
        else $error("underflow reported with two or more entries");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

/* test/postfix_stack_evaluator_test.sv */
// Self-checking testbench for postfix_stack_evaluator with random stimulus and a stack predictor.
module postfix_stack_evaluator_test;
    import pse_pkg::*;

    // All block inputs start at known values. Reset is held low from time zero.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    postfix_stack_evaluator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Characters waiting to be offered, and the reports predicted for accepted ones.
    t_in_item         pending_symbols[$];
    t_out_item        awaited_reports[$];
    logic [SYM_W-1:0] expr_symbols[$];

    // The testbench's own copy of the evaluation stack.
    logic [DATA_W-1:0] shadow_stack[STACK_DEPTH];
    int                shadow_fill = 0;

    int        in_count       = 0;
    int        mismatch_count = 0;
    int        hold_left      = 0;
    logic      hold_done      = 1'b0;
    t_out_item wanted;

    function automatic logic is_arith(input logic [SYM_W-1:0] sym);
        return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) || (sym == CH_SLASH);
    endfunction

    // Applies one character to the shadow stack and returns the report the block
    // must produce for it. An operator on fewer than two entries leaves the stack
    // alone; a push on a full stack is dropped. Division by zero pushes zero.
    function automatic t_out_item evaluate_symbol(input t_in_item item);
        t_out_item         report;
        t_status           st;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        logic [DATA_W-1:0] quot;
        st = STAT_OK;
        if (is_arith(item.symbol)) begin
            if (shadow_fill < 2) begin
                st = STAT_UNDERFLOW;
            end else begin
                rhs = shadow_stack[shadow_fill - 1];
                lhs = shadow_stack[shadow_fill - 2];
                case (item.symbol)
                    CH_PLUS: begin
                        res = lhs + rhs;
                    end
                    CH_MINUS: begin
                        res = lhs - rhs;
                    end
                    CH_STAR: begin
                        res = lhs * rhs;
                    end
                    default: begin
                        if (rhs == '0) begin
                            res = '0;
                            st  = STAT_DIVZERO;
                        end else begin
                            // Divide magnitudes and fix the sign afterwards so the
                            // quotient truncates toward zero. The most negative value
                            // over minus one wraps back onto itself.
                            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                            quot  = mag_l / mag_r;
                            res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quot : quot;
                        end
                    end
                endcase
                shadow_fill = shadow_fill - 1;
                shadow_stack[shadow_fill - 1] = res;
            end
        end else if (shadow_fill >= STACK_DEPTH) begin
            st = STAT_OVERFLOW;
        end else begin
            shadow_stack[shadow_fill] = DATA_W'(item.symbol) - DATA_W'(CH_ZERO);
            shadow_fill = shadow_fill + 1;
        end
        report.top_value = (shadow_fill > 0) ? shadow_stack[shadow_fill - 1] : '0;
        report.depth     = DEPTH_W'(shadow_fill);
        report.status    = st;
        report.final_res = item.last;
        // The depth is reported first; only then does a last character empty the stack.
        if (item.last) begin
            shadow_fill = 0;
        end
        return report;
    endfunction

    function automatic logic [SYM_W-1:0] random_operand();
        logic [SYM_W-1:0] b;
        if ($urandom_range(0, 99) < 70) begin
            b = SYM_W'($urandom_range(CH_ZERO, CH_ZERO + 9));
        end else begin
            do begin
                b = SYM_W'($urandom_range(0, 255));
            end while (is_arith(b));
        end
        return b;
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        logic [SYM_W-1:0] op;
        case ($urandom_range(0, 3))
            0: begin
                op = CH_PLUS;
            end
            1: begin
                op = CH_MINUS;
            end
            2: begin
                op = CH_STAR;
            end
            default: begin
                op = CH_SLASH;
            end
        endcase
        return op;
    endfunction

    task automatic queue_symbol(input logic [SYM_W-1:0] sym, input logic last);
        t_in_item item;
        item.symbol = sym;
        item.last   = last;
        pending_symbols.push_back(item);
    endtask

    // Moves the collected expression to the pending queue, marking its final character.
    task automatic flush_expression();
        for (int i = 0; i < expr_symbols.size(); i++) begin
            queue_symbol(expr_symbols[i], i == expr_symbols.size() - 1);
        end
        expr_symbols.delete();
    endtask

    // Stretch of accepted items during which neither side inserts random gaps.
    function automatic logic calm_window();
        return (in_count >= 150) && (in_count < 230);
    endfunction

    // Sender: a new character goes out only when the slot is free or its transfer
    // completes at this edge, so valid stays up with a steady payload until taken.
    // The report is predicted at the edge where the input transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_reports.push_back(evaluate_symbol(i_in_data));
                in_count <= in_count + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_symbols.size() > 0 &&
                    (calm_window() || $urandom_range(0, 99) >= 18)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_symbols.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Back-pressure: once, well into the run, the receiver refuses results until a
    // hold counter runs out. The block holds its one finished result and, with
    // one character in flight at a time, stops taking input while the sender
    // keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && in_count >= 320) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && (hold_left == 0) &&
                       (calm_window() || $urandom_range(0, 99) >= 18);
    end

    task automatic report_mismatch(input string what, input t_out_item exp_r,
                                   input t_out_item got_r);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected top %0d depth %0d status %0d last %0b, got top %0d depth %0d status %0d last %0b",
                     what, exp_r.top_value, exp_r.depth, exp_r.status, exp_r.final_res,
                     got_r.top_value, got_r.depth, got_r.status, got_r.final_res);
        end
    endtask

    // Receiver: every output transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reports.size() == 0) begin
                report_mismatch("unexpected result", '0, o_out_data);
            end else begin
                wanted = awaited_reports.pop_front();
                if (o_out_data !== wanted) begin
                    report_mismatch("result mismatch", wanted, o_out_data);
                end
            end
        end
    end

    initial begin
        int kind;
        int operands;
        int depth;
        int count;

        // Directed: an operator on the empty stack, the smallest and largest bytes
        // as operands, add and subtract, division by zero, then an operator with a
        // single entry on the stack.
        expr_symbols = '{CH_PLUS, 8'h00, 8'hFF, CH_MINUS, CH_ZERO + 8'd5, CH_PLUS,
                         CH_ZERO, CH_SLASH, CH_STAR};
        flush_expression();
        // Build the most negative value as 128^4 * 8, then divide it by 0 - 1.
        expr_symbols = '{CH_ZERO + 8'd128, CH_ZERO + 8'd128, CH_STAR, CH_ZERO + 8'd128,
                         CH_STAR, CH_ZERO + 8'd128, CH_STAR, CH_ZERO + 8'd8, CH_STAR,
                         CH_ZERO, CH_ZERO + 8'd1, CH_MINUS, CH_SLASH};
        flush_expression();

        // Random part: mostly well-formed expressions, some runs that overfill
        // the stack, and some raw noise with scattered last flags.
        while (pending_symbols.size() < 522) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                operands = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                        : $urandom_range(9, STACK_DEPTH);
                depth = 0;
                while (operands > 0 || depth > 1) begin
                    if (depth < 2 || (operands > 0 && $urandom_range(0, 1) == 1)) begin
                        expr_symbols.push_back(random_operand());
                        depth++;
                        operands--;
                    end else begin
                        expr_symbols.push_back(random_operator());
                        depth--;
                    end
                end
                flush_expression();
            end else if (kind < 85) begin
                count = STACK_DEPTH + $urandom_range(1, 4);
                repeat (count) expr_symbols.push_back(random_operand());
                count = $urandom_range(0, 3);
                repeat (count) expr_symbols.push_back(random_operator());
                flush_expression();
            end else begin
                count = $urandom_range(1, 10);
                repeat (count) begin
                    queue_symbol($urandom_range(0, 1) ? random_operator()
                                                      : SYM_W'($urandom_range(0, 255)),
                                 $urandom_range(0, 3) == 0);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_symbols.size() > 0 || i_in_valid) @(posedge i_clk);
        while (awaited_reports.size() > 0) @(posedge i_clk);
        // Longest operation is a divide; leave room for strays.
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("postfix_stack_evaluator verification clean");
        end else begin
            $display("postfix_stack_evaluator verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("postfix_stack_evaluator verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/pse_pkg.sv
src/pse_ram.sv
src/pse_alu.sv
src/postfix_stack_evaluator.sv
src/pse_checker.sv
test/postfix_stack_evaluator_test.sv
